/* rtl/dctd_pkg.sv */
// Shared constants, control word type and microcode program of the divisor counter.
`default_nettype none

package dctd_pkg;

    // Width of the integer that is factored, and how many table primes are tried.
    localparam int VALUE_BITS  = 32;
    localparam int NUM_PRIMES  = 168;
    localparam int TABLE_SIZE  = 168;
    localparam int PRIME_COUNT = (NUM_PRIMES > TABLE_SIZE) ? TABLE_SIZE : NUM_PRIMES;
    localparam int IDX_W       = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;

    localparam int IN_W    = 32;
    localparam int COUNT_W = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // The largest table prime is 997, so ten bits hold any prime and remainder.
    localparam int PRIME_W = 10;

    // The divider retires RADIX_BITS quotient bits per cycle.
    localparam int RADIX_BITS = 4;
    localparam int DIV_STEPS  = (VALUE_BITS + RADIX_BITS - 1) / RADIX_BITS;
    localparam int DIV_W      = DIV_STEPS * RADIX_BITS;
    localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // An exponent can reach VALUE_BITS - 1 at most.
    localparam int EXP_W  = $clog2(VALUE_BITS + 1);
    localparam int PROD_W = COUNT_W + EXP_W + 1;

    localparam logic [PRIME_W-1:0] PRIME_ROM [TABLE_SIZE] = '{
        10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
        10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
        10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
        10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
        10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
        10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
        10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
        10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
        10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
        10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
        10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
        10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
        10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
        10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
        10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
        10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
        10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769,
        10'd773, 10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827,
        10'd829, 10'd839, 10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881,
        10'd883, 10'd887, 10'd907, 10'd911, 10'd919, 10'd929, 10'd937, 10'd941,
        10'd947, 10'd953, 10'd967, 10'd971, 10'd977, 10'd983, 10'd991, 10'd997
    };

    // Datapath operations.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP      = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 3'd1;
    localparam logic [OP_W-1:0] OP_DIV_INIT = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 3'd3;
    localparam logic [OP_W-1:0] OP_FOLD     = 3'd4;
    localparam logic [OP_W-1:0] OP_EMIT     = 3'd5;
    localparam logic [OP_W-1:0] OP_TAKE     = 3'd6;

    // Jump conditions; when false the sequencer falls through to the next step.
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEVER       = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS      = 3'd1;
    localparam logic [COND_W-1:0] C_NO_ACCEPT   = 3'd2;
    localparam logic [COND_W-1:0] C_ZERO        = 3'd3;
    localparam logic [COND_W-1:0] C_DIV_BUSY    = 3'd4;
    localparam logic [COND_W-1:0] C_REM_ZERO    = 3'd5;
    localparam logic [COND_W-1:0] C_MORE_PRIMES = 3'd6;
    localparam logic [COND_W-1:0] C_OUT_FULL    = 3'd7;

    // Program addresses.
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_WAIT    = 4'd0;
    localparam logic [PC_W-1:0] PC_ZCHK    = 4'd1;
    localparam logic [PC_W-1:0] PC_DSTART  = 4'd2;
    localparam logic [PC_W-1:0] PC_DSTEP   = 4'd3;
    localparam logic [PC_W-1:0] PC_TEST    = 4'd4;
    localparam logic [PC_W-1:0] PC_NEXTP   = 4'd5;
    localparam logic [PC_W-1:0] PC_EMIT    = 4'd6;
    localparam logic [PC_W-1:0] PC_RESTART = 4'd7;
    localparam logic [PC_W-1:0] PC_TAKE    = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    // The control store.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_WAIT:    w = '{op: OP_LOAD,     cond: C_NO_ACCEPT,   target: PC_WAIT};
            PC_ZCHK:    w = '{op: OP_NOP,      cond: C_ZERO,        target: PC_EMIT};
            PC_DSTART:  w = '{op: OP_DIV_INIT, cond: C_NEVER,       target: PC_WAIT};
            PC_DSTEP:   w = '{op: OP_DIV_STEP, cond: C_DIV_BUSY,    target: PC_DSTEP};
            PC_TEST:    w = '{op: OP_NOP,      cond: C_REM_ZERO,    target: PC_TAKE};
            PC_NEXTP:   w = '{op: OP_FOLD,     cond: C_MORE_PRIMES, target: PC_DSTART};
            PC_EMIT:    w = '{op: OP_EMIT,     cond: C_OUT_FULL,    target: PC_EMIT};
            PC_RESTART: w = '{op: OP_NOP,      cond: C_ALWAYS,      target: PC_WAIT};
            PC_TAKE:    w = '{op: OP_TAKE,     cond: C_ALWAYS,      target: PC_DSTART};
            default:    w = '{op: OP_NOP,      cond: C_ALWAYS,      target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/divisor_count_trial_division.sv */
// Divisor counter: microcoded trial division over a table of primes below 1000.
//
// Usage. The input channel carries one integer per transfer on i_value, qualified by
// i_valid and held back by o_stall. The output channel carries one divisor count per
// transfer on o_divisor_count, qualified by o_valid and held back by i_stall. Every
// input transfer yields exactly one output transfer, in order.
//
// Operation. A small sequencer steps through a nine-word control store. For each
// table prime it runs one trial division on a shared radix-16 divider: a setup
// step, one divide step per four quotient bits (8 for 32-bit values), a test step
// and a fold or take step. Each factor that is divided out repeats the division
// with the same prime. A zero value goes from the zero check straight to the emit
// step and is answered with a count of 0. The block works on one value at a time:
// a new value is taken only in the wait step, once the previous count is emitted.
//
// Reset (synchronous, active low) returns the sequencer to its wait step and empties
// the output register. The output register parts the two sides: a new value is taken
// while a finished count still waits, and a stalled receiver only holds the sequencer
// in its emit step once the next count is ready too.
`default_nettype none

module divisor_count_trial_division
    import dctd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [IN_W-1:0]    i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [COUNT_W-1:0]      o_divisor_count
);

    // Sequencer state.
    logic [PC_W-1:0]       r_pc, n_pc;
    t_uword                uw;
    logic                  jump;

    // Datapath registers.
    logic [VALUE_BITS-1:0] r_val;
    logic [COUNT_W-1:0]    r_cnt;
    logic [EXP_W-1:0]      r_exp;
    logic [IDX_W-1:0]      r_idx;
    logic [PRIME_W-1:0]    r_prime;
    logic [PRIME_W-1:0]    r_rem;
    logic [DIV_W-1:0]      r_dq;
    logic [STEP_W-1:0]     r_step;

    // Output register.
    logic                  r_out_valid;
    logic [COUNT_W-1:0]    r_out_count;

    logic                  in_xfer;
    logic                  out_full;
    logic [VALUE_BITS-1:0] load_val;

    // One divider step: RADIX_BITS restoring subtract stages.
    logic [PRIME_W:0]      d_t;
    logic [PRIME_W-1:0]    d_rem;
    logic [DIV_W-1:0]      d_dq;

    logic [PROD_W-1:0]     prod;
    logic [COUNT_W-1:0]    fold_cnt;

    assign uw       = ucode(r_pc);
    assign o_stall  = (uw.op != OP_LOAD);
    assign in_xfer  = i_valid && !o_stall;
    assign out_full = r_out_valid && i_stall;
    assign load_val = VALUE_BITS'(i_value);

    assign o_valid         = r_out_valid;
    assign o_divisor_count = r_out_count;

    always_comb begin
        d_rem = r_rem;
        d_dq  = r_dq;
        d_t   = '0;
        for (int k = 0; k < RADIX_BITS; k++) begin
            d_t  = {d_rem, d_dq[DIV_W-1]};
            d_dq = {d_dq[DIV_W-2:0], 1'b0};
            if (d_t >= {1'b0, r_prime}) begin
                d_t      = d_t - {1'b0, r_prime};
                d_dq[0]  = 1'b1;
            end
            d_rem = d_t[PRIME_W-1:0];
        end
    end

    // Multiplying by one when the exponent is zero leaves the count alone, and a
    // saturated count stays saturated, so the fold needs no special case.
    assign prod     = PROD_W'(r_cnt) * PROD_W'({1'b0, r_exp} + 1'b1);
    assign fold_cnt = (prod > PROD_W'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_W-1:0];

    always_comb begin
        unique case (uw.cond)
            C_NEVER:       jump = 1'b0;
            C_ALWAYS:      jump = 1'b1;
            C_NO_ACCEPT:   jump = !in_xfer;
            C_ZERO:        jump = (r_val == '0);
            C_DIV_BUSY:    jump = (r_step != STEP_W'(DIV_STEPS - 1));
            C_REM_ZERO:    jump = (r_rem == '0);
            C_MORE_PRIMES: jump = (r_idx != IDX_W'(PRIME_COUNT - 1));
            C_OUT_FULL:    jump = out_full;
            default:       jump = 1'b1;
        endcase
        n_pc = jump ? uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (uw.op == OP_EMIT && !out_full) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (uw.op)
            OP_LOAD: begin
                if (in_xfer) begin
                    r_val <= load_val;
                    r_cnt <= (load_val == '0) ? '0 : COUNT_W'(1);
                    r_exp <= '0;
                    r_idx <= '0;
                end
            end
            OP_DIV_INIT: begin
                r_prime <= PRIME_ROM[r_idx];
                r_rem   <= '0;
                r_dq    <= DIV_W'(r_val);
                r_step  <= '0;
            end
            OP_DIV_STEP: begin
                r_rem  <= d_rem;
                r_dq   <= d_dq;
                r_step <= r_step + 1'b1;
            end
            OP_TAKE: begin
                r_val <= r_dq[VALUE_BITS-1:0];
                r_exp <= r_exp + 1'b1;
            end
            OP_FOLD: begin
                r_cnt <= fold_cnt;
                r_exp <= '0;
                r_idx <= r_idx + 1'b1;
            end
            OP_EMIT: begin
                if (!out_full) begin
                    r_out_count <= r_cnt;
                end
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    // An accepted value always goes to the zero check next.
    a_accept_to_zchk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_pc == PC_ZCHK))
        else $error("sequencer did not leave the wait step after a transfer");

    // A factor is only divided out after a zero remainder.
    a_take_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_TAKE) |-> (r_rem == '0))
        else $error("quotient taken with a nonzero remainder");

    // The divider never runs with a divisor below two.
    a_prime_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_DSTEP) |-> (r_prime >= PRIME_W'(2)))
        else $error("divider started without a table prime");

    // The prime index never runs past the table.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_DSTART) |-> (r_idx <= IDX_W'(PRIME_COUNT - 1)))
        else $error("prime index past the end of the table");

    // A count is written only while the output register can take it.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pc == PC_EMIT) && !out_full) |=> r_out_valid)
        else $error("emit step did not fill the output register");

endmodule

`default_nettype wire
